// File: design/dhtm_pkg.sv
// types, constants and arithmetic helpers for the dh link transform
`default_nettype none

package dhtm_pkg;

   localparam int ANG_W  = 31;
   localparam int LEN_W  = 32;
   localparam int ROT_W  = 32;
   localparam int U_W    = 33;
   localparam int P_W    = 31;
   localparam int CSR_W  = 3;
   localparam int NUM_POLY = 5;

   localparam int THETA = 0;
   localparam int ALPHA = 1;
   localparam int SIN_CH = 0;
   localparam int COS_CH = 1;

   // pi/2 in q4.28 and the bias that makes the reduced angle non-negative
   localparam logic [U_W-1:0] HP      = 33'd421657428;
   localparam logic [U_W-1:0] HALF_HP = 33'd210828714;
   localparam logic [U_W-1:0] U_BIAS  = 33'd3584088138;
   localparam logic [P_W-1:0] QONE    = 31'h4000_0000;

   // horner divisors per cell, zero leaves the channel untouched
   localparam int SIN_K [NUM_POLY] = '{0, 72, 42, 20, 6};
   localparam int COS_K [NUM_POLY] = '{90, 56, 30, 12, 2};

   typedef enum logic [CSR_W-1:0] {
      CSR_LINK_LENGTH  = 3'd0,
      CSR_LINK_OFFSET  = 3'd1,
      CSR_TWIST_OFFSET = 3'd2,
      CSR_JOINT_OFFSET = 3'd3,
      CSR_TURN_AXIS    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [U_W-1:0] u;
      logic [1:0]     quad;
   } red_lane_type;

   typedef struct packed {
      red_lane_type [1:0] lane;
   } red_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic [P_W-1:0]          x2;
      logic [1:0]              quad;
      logic [1:0][P_W-1:0]     p;
   } poly_lane_type;

   typedef struct packed {
      poly_lane_type [1:0] lane;
   } poly_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] m00;
      logic signed [ROT_W-1:0] m01;
      logic signed [ROT_W-1:0] m02;
      logic signed [LEN_W-1:0] m03;
      logic signed [ROT_W-1:0] m10;
      logic signed [ROT_W-1:0] m11;
      logic signed [ROT_W-1:0] m12;
      logic signed [LEN_W-1:0] m13;
      logic signed [ROT_W-1:0] m21;
      logic signed [ROT_W-1:0] m22;
      logic signed [LEN_W-1:0] m23;
   } rsp_type;

   // q2.30 product, rounded half away from zero
   function automatic logic signed [34:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic        neg;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] pr;
      logic [33:0] r;
      neg = a[31] ^ b[31];
      ma  = a[31] ? 32'(-a) : 32'(a);
      mb  = b[31] ? 32'(-b) : 32'(b);
      pr  = 64'(ma) * 64'(mb);
      r   = 34'((pr + 64'd536870912) >> 30);
      return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
   endfunction

   function automatic logic signed [31:0] clamp_rot(input logic signed [35:0] v);
      if (v > 36'sd1073741824) begin
         return 32'sd1073741824;
      end else if (v < -36'sd1073741824) begin
         return -32'sd1073741824;
      end else begin
         return 32'(v);
      end
   endfunction

   function automatic logic signed [31:0] clamp_len(input logic signed [34:0] v);
      if (v > 35'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -35'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return 32'(v);
      end
   endfunction

endpackage

`default_nettype wire

// File: design/dhtm_reduce_cell.sv
// one restoring step of the quadrant reduction for both angles
`default_nettype none

module dhtm_reduce_cell
   import dhtm_pkg::*;
#(
   parameter int SH = 0
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    adv,
   input  wire logic    in_valid,
   input  wire red_type in_data,
   output logic         out_valid,
   output red_type      out_data
);

   localparam logic [U_W-1:0] STEP = U_W'(HP << SH);

   logic    valid_ff;
   red_type data_ff;
   red_type data_in;

   always_comb begin
      data_in = in_data;
      for (int l = 0; l < 2; l++) begin
         if (in_data.lane[l].u >= STEP) begin
            data_in.lane[l].u = in_data.lane[l].u - STEP;
            if (SH == 1) begin
               data_in.lane[l].quad[1] = 1'b1;
            end else if (SH == 0) begin
               data_in.lane[l].quad[0] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: design/dhtm_poly_cell.sv
// one horner step p = one - x2*p/k on sine and cosine of both angles
`default_nettype none

module dhtm_poly_cell
   import dhtm_pkg::*;
#(
   parameter int KS = 0,
   parameter int KC = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     adv,
   input  wire logic     in_valid,
   input  wire poly_type in_data,
   output logic          out_valid,
   output poly_type      out_data
);

   localparam int K [2] = '{KS, KC};
   localparam logic [31:0] MS = 32'(64'd4294967296 / ((KS == 0) ? 1 : KS));
   localparam logic [31:0] MC = 32'(64'd4294967296 / ((KC == 0) ? 1 : KC));
   localparam logic [1:0][31:0] M = {MC, MS};

   logic                  a_valid_ff;
   poly_type              a_data_ff;
   logic [1:0][1:0][31:0] a_t_ff;
   logic [1:0][1:0][31:0] a_t_in;

   logic                  b_valid_ff;
   poly_type              b_data_ff;
   logic [1:0][1:0][31:0] b_t_ff;
   logic [1:0][1:0][31:0] b_q_ff;
   logic [1:0][1:0][31:0] b_q_in;

   logic                  c_valid_ff;
   poly_type              c_data_ff;
   poly_type              c_data_in;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         for (int c = 0; c < 2; c++) begin
            a_t_in[l][c] = 32'((63'(in_data.lane[l].x2) * 63'(in_data.lane[l].p[c])
                              + 63'd536870912) >> 30);
            b_q_in[l][c] = 32'((64'(a_t_ff[l][c]) * 64'(M[c])) >> 32);
         end
      end
   end

   always_comb begin
      logic [31:0] rem;
      logic [31:0] qf;
      c_data_in = b_data_ff;
      for (int l = 0; l < 2; l++) begin
         for (int c = 0; c < 2; c++) begin
            rem = b_t_ff[l][c] - 32'(b_q_ff[l][c] * 32'(K[c]));
            qf  = b_q_ff[l][c] + ((rem >= 32'(K[c])) ? 32'd1 : 32'd0);
            if (K[c] != 0) begin
               c_data_in.lane[l].p[c] = QONE - P_W'(qf);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_data_ff <= in_data;
         a_t_ff    <= a_t_in;
         b_data_ff <= a_data_ff;
         b_t_ff    <= a_t_ff;
         b_q_ff    <= b_q_in;
         c_data_ff <= c_data_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_data_ff;

endmodule

`default_nettype wire

// File: design/dhtm_out_buf.sv
// two-entry result buffer between the pipeline and the result channel
`default_nettype none

module dhtm_out_buf
   import dhtm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rsp_type      out_data
);

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/dh_transform_matrix_top.sv
// dh link transform: joint angle in, variable matrix entries out
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_joint_angle (q3.28)
//   rsp      out        rsp_valid/rsp_stall  rsp_m00..rsp_m23 (q2.30, q16.16)
//   csr      in         csr_write            csr_index, csr_wdata
//
// one item per cycle while the result buffer is not full
// the pipe runs the reduction, five horner cells of three stages each, then fold and products
// synchronous reset, registers return to a = d = alpha = theta = 0, z axis
// a stalled result sits in a two-entry buffer; the pipe freezes once it is full
`default_nettype none

module dh_transform_matrix_top
   import dhtm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [ANG_W-1:0] req_joint_angle,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [ROT_W-1:0]      rsp_m00,
   output logic signed [ROT_W-1:0]      rsp_m01,
   output logic signed [ROT_W-1:0]      rsp_m02,
   output logic signed [LEN_W-1:0]      rsp_m03,
   output logic signed [ROT_W-1:0]      rsp_m10,
   output logic signed [ROT_W-1:0]      rsp_m11,
   output logic signed [ROT_W-1:0]      rsp_m12,
   output logic signed [LEN_W-1:0]      rsp_m13,
   output logic signed [ROT_W-1:0]      rsp_m21,
   output logic signed [ROT_W-1:0]      rsp_m22,
   output logic signed [LEN_W-1:0]      rsp_m23,
   input  wire logic                    csr_write,
   input  wire logic [CSR_W-1:0]        csr_index,
   input  wire logic [LEN_W-1:0]        csr_wdata
);

   logic signed [LEN_W-1:0] link_length_ff;
   logic signed [LEN_W-1:0] link_offset_ff;
   logic signed [ANG_W-1:0] twist_offset_ff;
   logic signed [ANG_W-1:0] joint_offset_ff;
   logic                    turn_axis_ff;

   logic adv;
   logic buf_full;

   logic    e_valid_ff;
   red_type e_data_ff;
   red_type e_data_in;

   logic    red_valid [4];
   red_type red_data  [4];

   logic                      x_valid_ff;
   logic [1:0][ROT_W-1:0]     x_ff;
   logic [1:0][1:0]           x_quad_ff;
   logic [1:0][ROT_W-1:0]     x_in;

   logic     poly_valid [NUM_POLY+1];
   poly_type poly_data  [NUM_POLY+1];
   poly_type x2_in;
   logic     x2_valid_ff;
   poly_type x2_data_ff;

   logic                   f1_valid_ff;
   logic [1:0][34:0]       f1_sn_ff;
   logic [1:0][P_W-1:0]    f1_cs_ff;
   logic [1:0][1:0]        f1_quad_ff;

   logic                   f2_valid_ff;
   logic [1:0][ROT_W-1:0]  f2_s_ff;
   logic [1:0][ROT_W-1:0]  f2_c_ff;
   logic [1:0][ROT_W-1:0]  f2_s_in;
   logic [1:0][ROT_W-1:0]  f2_c_in;

   logic                    f3_valid_ff;
   logic signed [ROT_W-1:0] f3_st_ff;
   logic signed [ROT_W-1:0] f3_ct_ff;
   logic signed [ROT_W-1:0] f3_sa_ff;
   logic signed [ROT_W-1:0] f3_ca_ff;
   logic signed [34:0]      f3_stca_ff;
   logic signed [34:0]      f3_stsa_ff;
   logic signed [34:0]      f3_act_ff;
   logic signed [34:0]      f3_ctca_ff;
   logic signed [34:0]      f3_ctsa_ff;
   logic signed [34:0]      f3_ast_ff;

   rsp_type push_data;
   rsp_type out_data;

   assign adv       = !buf_full;
   assign req_stall = buf_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         link_length_ff  <= '0;
         link_offset_ff  <= '0;
         twist_offset_ff <= '0;
         joint_offset_ff <= '0;
         turn_axis_ff    <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LINK_LENGTH:  link_length_ff  <= csr_wdata;
            CSR_LINK_OFFSET:  link_offset_ff  <= csr_wdata;
            CSR_TWIST_OFFSET: twist_offset_ff <= csr_wdata[ANG_W-1:0];
            CSR_JOINT_OFFSET: joint_offset_ff <= csr_wdata[ANG_W-1:0];
            CSR_TURN_AXIS:    turn_axis_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // angle sums, biased so the reduction sees a non-negative value
   always_comb begin
      logic signed [31:0] th_sum;
      logic signed [31:0] al_sum;
      th_sum = 32'(joint_offset_ff) + (turn_axis_ff ? 32'(req_joint_angle) : 32'sd0);
      al_sum = 32'(twist_offset_ff) + (turn_axis_ff ? 32'sd0 : 32'(req_joint_angle));
      e_data_in.lane[THETA].u    = U_W'(34'(th_sum) + 34'(U_BIAS));
      e_data_in.lane[ALPHA].u    = U_W'(34'(al_sum) + 34'(U_BIAS));
      e_data_in.lane[THETA].quad = 2'd0;
      e_data_in.lane[ALPHA].quad = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_data_ff <= e_data_in;
      end
   end

   // quadrant reduction: subtract 8, 4, 2, 1 times pi/2
   for (genvar i = 0; i < 4; i++) begin : g_red
      if (i == 0) begin : g_first
         dhtm_reduce_cell #(.SH(3 - i)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .in_valid  (e_valid_ff),
            .in_data   (e_data_ff),
            .out_valid (red_valid[i]),
            .out_data  (red_data[i])
         );
      end else begin : g_next
         dhtm_reduce_cell #(.SH(3 - i)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .in_valid  (red_valid[i-1]),
            .in_data   (red_data[i-1]),
            .out_valid (red_valid[i]),
            .out_data  (red_data[i])
         );
      end
   end

   // residue centered on zero, scaled to q2.30
   always_comb begin
      logic [33:0] diff;
      for (int l = 0; l < 2; l++) begin
         diff    = {1'b0, red_data[3].lane[l].u} - {1'b0, HALF_HP};
         x_in[l] = {diff[29:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff  <= 1'b0;
         x2_valid_ff <= 1'b0;
      end else if (adv) begin
         x_valid_ff  <= red_valid[3];
         x2_valid_ff <= x_valid_ff;
      end
   end

   always_comb begin
      logic signed [34:0] sq;
      for (int l = 0; l < 2; l++) begin
         sq                    = qmul($signed(x_ff[l]), $signed(x_ff[l]));
         x2_in.lane[l].x       = $signed(x_ff[l]);
         x2_in.lane[l].x2      = sq[P_W-1:0];
         x2_in.lane[l].quad    = x_quad_ff[l];
         x2_in.lane[l].p[SIN_CH] = QONE;
         x2_in.lane[l].p[COS_CH] = QONE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff       <= x_in;
         x_quad_ff  <= {red_data[3].lane[1].quad, red_data[3].lane[0].quad};
         x2_data_ff <= x2_in;
      end
   end

   assign poly_valid[0] = x2_valid_ff;
   assign poly_data[0]  = x2_data_ff;

   for (genvar i = 0; i < NUM_POLY; i++) begin : g_poly
      dhtm_poly_cell #(.KS(SIN_K[i]), .KC(COS_K[i])) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (poly_valid[i]),
         .in_data   (poly_data[i]),
         .out_valid (poly_valid[i+1]),
         .out_data  (poly_data[i+1])
      );
   end

   // sine = x * p, cosine is the last horner value
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= poly_valid[NUM_POLY];
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            f1_sn_ff[l]   <= qmul(poly_data[NUM_POLY].lane[l].x,
                                  32'(poly_data[NUM_POLY].lane[l].p[SIN_CH]));
            f1_cs_ff[l]   <= poly_data[NUM_POLY].lane[l].p[COS_CH];
            f1_quad_ff[l] <= poly_data[NUM_POLY].lane[l].quad;
         end
      end
   end

   // quadrant fold and clamp
   always_comb begin
      logic signed [35:0] sn;
      logic signed [35:0] cs;
      logic signed [35:0] rs;
      logic signed [35:0] rc;
      for (int l = 0; l < 2; l++) begin
         sn = 36'($signed(f1_sn_ff[l]));
         cs = $signed({5'b0, f1_cs_ff[l]});
         unique case (f1_quad_ff[l])
            2'd0: begin
               rs = sn;
               rc = cs;
            end
            2'd1: begin
               rs = cs;
               rc = -sn;
            end
            2'd2: begin
               rs = -sn;
               rc = -cs;
            end
            default: begin
               rs = -cs;
               rc = sn;
            end
         endcase
         f2_s_in[l] = clamp_rot(rs);
         f2_c_in[l] = clamp_rot(rc);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_s_ff <= f2_s_in;
         f2_c_ff <= f2_c_in;
      end
   end

   // matrix products
   always_ff @(posedge clock) begin
      if (adv) begin
         f3_st_ff   <= $signed(f2_s_ff[THETA]);
         f3_ct_ff   <= $signed(f2_c_ff[THETA]);
         f3_sa_ff   <= $signed(f2_s_ff[ALPHA]);
         f3_ca_ff   <= $signed(f2_c_ff[ALPHA]);
         f3_stca_ff <= qmul($signed(f2_s_ff[THETA]), $signed(f2_c_ff[ALPHA]));
         f3_stsa_ff <= qmul($signed(f2_s_ff[THETA]), $signed(f2_s_ff[ALPHA]));
         f3_ctca_ff <= qmul($signed(f2_c_ff[THETA]), $signed(f2_c_ff[ALPHA]));
         f3_ctsa_ff <= qmul($signed(f2_c_ff[THETA]), $signed(f2_s_ff[ALPHA]));
         f3_act_ff  <= qmul(link_length_ff, $signed(f2_c_ff[THETA]));
         f3_ast_ff  <= qmul(link_length_ff, $signed(f2_s_ff[THETA]));
      end
   end

   always_comb begin
      push_data.m00 = f3_ct_ff;
      push_data.m01 = -clamp_rot(36'(f3_stca_ff));
      push_data.m02 = clamp_rot(36'(f3_stsa_ff));
      push_data.m03 = clamp_len(f3_act_ff);
      push_data.m10 = f3_st_ff;
      push_data.m11 = clamp_rot(36'(f3_ctca_ff));
      push_data.m12 = -clamp_rot(36'(f3_ctsa_ff));
      push_data.m13 = clamp_len(f3_ast_ff);
      push_data.m21 = f3_sa_ff;
      push_data.m22 = f3_ca_ff;
      push_data.m23 = link_offset_ff;
   end

   dhtm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (f3_valid_ff && adv),
      .push_data (push_data),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_m00 = out_data.m00;
   assign rsp_m01 = out_data.m01;
   assign rsp_m02 = out_data.m02;
   assign rsp_m03 = out_data.m03;
   assign rsp_m10 = out_data.m10;
   assign rsp_m11 = out_data.m11;
   assign rsp_m12 = out_data.m12;
   assign rsp_m13 = out_data.m13;
   assign rsp_m21 = out_data.m21;
   assign rsp_m22 = out_data.m22;
   assign rsp_m23 = out_data.m23;

`ifndef ASSERT_OFF
   a_freeze_when_full: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(f3_valid_ff))
      else $error("pipeline moved while result buffer full");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> e_valid_ff)
      else $error("accepted item missing from entry stage");

   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m00 <= 32'sd1073741824) && (rsp_m00 >= -32'sd1073741824)
                 && (rsp_m21 <= 32'sd1073741824) && (rsp_m21 >= -32'sd1073741824))
      else $error("rotation entry outside unit range");
`endif

endmodule

`default_nettype wire
